@@ rtl/core/fxalu_pkg.sv @@
// Package: shared types, opcodes and constants for the Q24.8 arithmetic unit.
package fxalu_pkg;

    localparam int DataWidth = 32;
    localparam int FracBitsDefault = 8;

    typedef enum logic [3:0] {
        FUNC_ADD      = 4'd0,
        FUNC_SUB      = 4'd1,
        FUNC_MUL      = 4'd2,
        FUNC_DIV      = 4'd3,
        FUNC_MIN      = 4'd4,
        FUNC_MAX      = 4'd5,
        FUNC_INC      = 4'd6,
        FUNC_DEC      = 4'd7,
        FUNC_FROM_INT = 4'd8,
        FUNC_TO_INT   = 4'd9
    } func_t;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               divide_by_zero;
    } out_beat_t;

    // Per-item context carried along the divider chain.
    typedef struct packed {
        logic               valid;
        logic               is_div;
        logic               dz;
        logic               neg;
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
    } ctx_t;

endpackage

@@ rtl/core/fxalu_div_cell.sv @@
// Divider cell: one restoring quotient bit per cell, registered, enable-stalled.
module fxalu_div_cell #(
    parameter int QW = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  fxalu_pkg::ctx_t      ctx_in,
    input  logic [QW-1:0]        rem_in,
    input  logic [QW-1:0]        quo_in,
    input  logic [31:0]          den_in,
    output fxalu_pkg::ctx_t      ctx_out,
    output logic [QW-1:0]        rem_out,
    output logic [QW-1:0]        quo_out,
    output logic [31:0]          den_out
);
    logic [QW:0]   trial;
    logic [QW:0]   diff;
    logic          take;
    fxalu_pkg::ctx_t ctx_reg;
    logic [QW-1:0] rem_reg, quo_reg;
    logic [31:0]   den_reg;

    // Shift next dividend bit (quo MSB) into remainder, try subtract.
    assign trial = {rem_in, quo_in[QW-1]};
    assign diff  = trial - {{(QW-31){1'b0}}, den_in};
    assign take  = ~diff[QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.valid <= 1'b0;
        end else if (en) begin
            ctx_reg <= ctx_in;
        end
        if (en) begin
            rem_reg <= take ? diff[QW-1:0] : trial[QW-1:0];
            quo_reg <= {quo_in[QW-2:0], take};
            den_reg <= den_in;
        end
    end

    assign ctx_out = ctx_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign den_out = den_reg;
endmodule

@@ rtl/core/fixed_point_q24_8_alu.sv @@
// Top level: pipelined signed fixed-point arithmetic unit with divider cell chain.
//
//  channel | ports                         | dir | payload
//  input   | s_valid s_ready s_data        | in  | fxalu_pkg::in_beat_t
//  result  | m_valid m_ready m_data        | out | fxalu_pkg::out_beat_t
//
// Stages: one front stage, one divider cell per quotient bit, one output
// stage. Throughput one beat per cycle while m_ready does not stall the chain.
// All operations ride the same chain so results leave in order.
// Reset clears every valid bit; payload registers are not reset.
// The whole chain advances when the output register is empty or being taken,
// so a stall on m_ready freezes it; s_ready follows that advance.
module fixed_point_q24_8_alu #(
    parameter int FRACTION_BITS = fxalu_pkg::FracBitsDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fxalu_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fxalu_pkg::out_beat_t  m_data
);
    localparam int QW    = 32 + FRACTION_BITS;  // quotient / dividend width
    localparam int CELLS = QW;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- front stage: everything except divide ----------------
    logic signed [31:0] a, b;
    logic signed [63:0] prod;
    logic signed [31:0] res_c;
    logic lt, eq, gt;
    logic [31:0] abs_a, abs_b;

    assign a    = s_data.operand_a;
    assign b    = s_data.operand_b;
    assign prod = a * b;
    assign lt   = a < b;
    assign eq   = a == b;
    assign gt   = a > b;
    assign abs_a = a[31] ? 32'(-a) : 32'(a);
    assign abs_b = b[31] ? 32'(-b) : 32'(b);

    always_comb begin
        unique case (s_data.func)
            fxalu_pkg::FUNC_ADD:      res_c = a + b;
            fxalu_pkg::FUNC_SUB:      res_c = a - b;
            fxalu_pkg::FUNC_MUL:      res_c = 32'(prod >>> FRACTION_BITS);
            fxalu_pkg::FUNC_MIN:      res_c = lt ? a : b;
            fxalu_pkg::FUNC_MAX:      res_c = gt ? a : b;
            fxalu_pkg::FUNC_INC:      res_c = a + 32'sd1;
            fxalu_pkg::FUNC_DEC:      res_c = a - 32'sd1;
            fxalu_pkg::FUNC_FROM_INT: res_c = a <<< FRACTION_BITS;
            fxalu_pkg::FUNC_TO_INT:   res_c = a >>> FRACTION_BITS;
            default:                  res_c = '0;
        endcase
    end

    fxalu_pkg::ctx_t ctx_next;
    always_comb begin
        ctx_next.valid     = s_valid;
        ctx_next.is_div    = s_data.func == fxalu_pkg::FUNC_DIV;
        ctx_next.dz        = ctx_next.is_div && (b == '0);
        ctx_next.neg       = a[31] ^ b[31];
        ctx_next.result    = res_c;
        ctx_next.a_less    = lt;
        ctx_next.a_equal   = eq;
        ctx_next.a_greater = gt;
    end

    fxalu_pkg::ctx_t ctx_reg;
    logic [QW-1:0]   dvd_reg;
    logic [31:0]     den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.valid <= 1'b0;
        end else if (adv) begin
            ctx_reg <= ctx_next;
        end
        if (adv) begin
            dvd_reg <= {abs_a, {FRACTION_BITS{1'b0}}};
            den_reg <= abs_b;
        end
    end

    // ---------------- divider chain ----------------
    fxalu_pkg::ctx_t ctx_w [CELLS+1];
    logic [QW-1:0]   rem_w [CELLS+1];
    logic [QW-1:0]   quo_w [CELLS+1];
    logic [31:0]     den_w [CELLS+1];

    assign ctx_w[0] = ctx_reg;
    assign rem_w[0] = '0;
    assign quo_w[0] = dvd_reg;
    assign den_w[0] = den_reg;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        fxalu_div_cell #(.QW(QW)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctx_in  (ctx_w[i]),
            .rem_in  (rem_w[i]),
            .quo_in  (quo_w[i]),
            .den_in  (den_w[i]),
            .ctx_out (ctx_w[i+1]),
            .rem_out (rem_w[i+1]),
            .quo_out (quo_w[i+1]),
            .den_out (den_w[i+1])
        );
    end

    // ---------------- output register ----------------
    fxalu_pkg::ctx_t    tail;
    logic [QW-1:0]      q_mag;
    logic signed [31:0] q_res;
    fxalu_pkg::out_beat_t out_next;
    fxalu_pkg::out_beat_t out_reg;
    logic               m_valid_reg;

    assign tail  = ctx_w[CELLS];
    assign q_mag = quo_w[CELLS];
    assign q_res = tail.neg ? 32'(-q_mag) : 32'(q_mag);

    always_comb begin
        out_next.a_less         = tail.a_less;
        out_next.a_equal        = tail.a_equal;
        out_next.a_greater      = tail.a_greater;
        out_next.divide_by_zero = tail.dz;
        priority if (tail.dz) begin
            out_next.result = '0;
        end else if (tail.is_div) begin
            out_next.result = q_res;
        end else begin
            out_next.result = tail.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tail.valid;
        end
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ---------------- assertions ----------------
    a_div_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.divide_by_zero |-> m_data.result == '0)
        else $error("divide by zero with nonzero result");

    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_data.a_less, m_data.a_equal, m_data.a_greater}))
        else $error("compare flags not one-hot");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output changed during stall");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready out of step with output stage");
endmodule
